### hdl/sdwm_pkg.sv
`default_nettype none

package sdwm_pkg;

  localparam int DATA_W = 64;
  localparam int HALF_W = 32;
  localparam int CNT_W  = 6;
  localparam int MODE_W = 2;
  localparam int PAIR_W = 2 * DATA_W;

  localparam logic [MODE_W-1:0] MODE_32_32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_64_64 = 2'd2;

  localparam logic [DATA_W-1:0] MIN_VAL  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ONE_VAL  = {{(DATA_W-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DATA_W-1:0] sext_half(input logic [DATA_W-1:0] v);
    return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  function automatic logic [DATA_W-1:0] neg_val(input logic [DATA_W-1:0] v);
    return (~v) + ONE_VAL;
  endfunction

endpackage

`default_nettype wire

### hdl/sdwm_core.sv
`default_nettype none

module sdwm_core
  import sdwm_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire [DATA_W-1:0] dividend,
  input  wire [DATA_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DATA_W-1:0] quo,
  output logic [DATA_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // restore on a negative trial difference
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

`default_nettype wire

### hdl/signed_divider_with_width_modes.sv
// Signed divider with operand width modes.
// Input channel in_*: one divide request per handshake. in_tuser carries the
// mode (0 = 32/32, 1 or 3 = 64/32, 2 = 64/64), in_tdata the numerator in the
// low 64 bits and the denominator in the high 64 bits.
// Output channel out_*: one result per request. out_tdata carries the
// quotient (low 64 bits) and the remainder (high 64 bits), out_tuser the
// error flag (zero divisor, or minimum value over minus one).
// A regular divide goes through the radix-2 restoring unit, which resolves
// one quotient bit per cycle, then through the hold state and the output
// register. An error case skips the unit and goes straight to the hold state.
// in_tready is high only while no request is in work, so the block takes
// no new request until the last one leaves the sequencer. A finished result
// sits in the output register; the next request is taken while it waits,
// and a second waits in the sequencer until the receiver takes the first.
// Reset (rst_n low, synchronous) drops any request in work, clears
// out_tvalid and sets the held remainder to zero.
`default_nettype none

module signed_divider_with_width_modes
  import sdwm_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire [PAIR_W-1:0]   in_tdata,   // numerator, denominator
  input  wire [MODE_W-1:0]   in_tuser,   // mode
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [PAIR_W-1:0]  out_tdata,  // quotient, remainder
  output logic [0:0]         out_tuser   // error_flag
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic              q_neg_r, q_neg_nxt;
  logic              r_neg_r, r_neg_nxt;
  logic [DATA_W-1:0] res_q_r, res_q_nxt;
  logic [DATA_W-1:0] res_rem_r, res_rem_nxt;
  logic              res_err_r, res_err_nxt;
  logic              res_keep_r, res_keep_nxt;
  logic [DATA_W-1:0] out_q_r, out_q_nxt;
  logic [DATA_W-1:0] out_rem_r, out_rem_nxt;
  logic              out_err_r, out_err_nxt;

  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] num_n, den_n, un, ud;
  logic              accept, den_zero, ovf, start;
  div_stat_t         stat;
  logic [DATA_W-1:0] core_quo, core_rem;

  assign mode     = in_tuser;
  assign num_n    = (mode == MODE_32_32) ? sext_half(in_tdata[DATA_W-1:0])
                                         : in_tdata[DATA_W-1:0];
  assign den_n    = (mode != MODE_64_64) ? sext_half(in_tdata[PAIR_W-1:DATA_W])
                                         : in_tdata[PAIR_W-1:DATA_W];
  assign den_zero = (den_n == '0);
  assign ovf      = (num_n == MIN_VAL) && (den_n == ALL_ONES);
  assign un       = num_n[DATA_W-1] ? neg_val(num_n) : num_n;
  assign ud       = den_n[DATA_W-1] ? neg_val(den_n) : den_n;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign start     = accept && !den_zero && !ovf;

  sdwm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (un),
    .divisor  (ud),
    .stat     (stat),
    .quo      (core_quo),
    .rem      (core_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    held_nxt       = held_r;
    q_neg_nxt      = q_neg_r;
    r_neg_nxt      = r_neg_r;
    res_q_nxt      = res_q_r;
    res_rem_nxt    = res_rem_r;
    res_err_nxt    = res_err_r;
    res_keep_nxt   = res_keep_r;
    out_q_nxt      = out_q_r;
    out_rem_nxt    = out_rem_r;
    out_err_nxt    = out_err_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          q_neg_nxt = num_n[DATA_W-1] ^ den_n[DATA_W-1];
          r_neg_nxt = num_n[DATA_W-1];
          if (den_zero) begin
            res_q_nxt    = num_n[DATA_W-1] ? ONE_VAL : '0;
            res_rem_nxt  = num_n;
            res_err_nxt  = 1'b1;
            res_keep_nxt = 1'b0;
            state_nxt    = S_HOLD;
          end else if (ovf) begin
            res_q_nxt    = num_n;
            res_err_nxt  = 1'b1;
            res_keep_nxt = 1'b1;
            state_nxt    = S_HOLD;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat.done) begin
          res_q_nxt    = q_neg_r ? neg_val(core_quo) : core_quo;
          res_rem_nxt  = r_neg_r ? neg_val(core_rem) : core_rem;
          res_err_nxt  = 1'b0;
          res_keep_nxt = 1'b0;
          state_nxt    = S_HOLD;
        end
      end
      S_HOLD: begin
        // hand over once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_q_nxt      = res_q_r;
          out_rem_nxt    = res_keep_r ? held_r : res_rem_r;
          out_err_nxt    = res_err_r;
          held_nxt       = res_keep_r ? held_r : res_rem_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      held_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      held_r       <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_neg_r    <= q_neg_nxt;
    r_neg_r    <= r_neg_nxt;
    res_q_r    <= res_q_nxt;
    res_rem_r  <= res_rem_nxt;
    res_err_r  <= res_err_nxt;
    res_keep_r <= res_keep_nxt;
    out_q_r    <= out_q_nxt;
    out_rem_r  <= out_rem_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_rem_r, out_q_r};
  assign out_tuser  = out_err_r;

endmodule

`default_nettype wire

### hdl/sdwm_checker.sv
`default_nettype none

module sdwm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire [127:0] in_tdata,
  input wire [1:0]   in_tuser,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [127:0] out_tdata,
  input wire [0:0]   out_tuser
);

  logic [63:0] chk_q;
  assign chk_q = out_tdata[63:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  a_err_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (chk_q == 64'h0 || chk_q == 64'h1 || chk_q == 64'h8000_0000_0000_0000))
    else $error("error result with unexpected quotient");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the result channel");

endmodule

bind signed_divider_with_width_modes sdwm_checker u_sdwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
